FILE: rtl/rfpd_pkg.sv
// ----------------------------------------------------------------------------
// rfpd_pkg: shared types and constants of the radial field point deformer
// Payload structs, register codes and fixed-point widths used by all modules.
// ----------------------------------------------------------------------------
package rfpd_pkg;

    // Fixed-point format of all coordinates.
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] ONE = 17'(1) << FRAC_BITS;

    // Square root: one result bit per stage, 33 result bits.
    localparam int SQ_STEPS = 33;
    // Direction divider: 17 quotient bits, covering 0 .. 1.0 inclusive.
    localparam int DIR_QBITS = FRAC_BITS + 1;
    // Weight divider: 16 quotient bits, results of 1.0 or more are caught ahead.
    localparam int WT_QBITS = FRAC_BITS;

    // Configuration register codes.
    localparam logic [7:0] CFG_FORCE   = 8'd0;
    localparam logic [7:0] CFG_RADFALL = 8'd1;
    localparam logic [7:0] CFG_CENTRE_X = 8'd2;
    localparam logic [7:0] CFG_CENTRE_Y = 8'd3;
    localparam logic [7:0] CFG_CENTRE_Z = 8'd4;
    localparam logic [7:0] CFG_SHIFT_X = 8'd5;
    localparam logic [7:0] CFG_SHIFT_Y = 8'd6;
    localparam logic [7:0] CFG_SHIFT_Z = 8'd7;

    localparam logic [62:0] RADFALL_RESET = 63'h0000_8000_0000_8000;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] moved_x;
        logic signed [31:0] moved_y;
        logic signed [31:0] moved_z;
    } moved_t;

    // Side data that travels next to the square root.
    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][31:0] a;
        logic [2:0]       neg;
    } side_t;

endpackage

FILE: rtl/rfpd_sqrt.sv
// ----------------------------------------------------------------------------
// rfpd_sqrt: pipelined integer square root
// Floor square root of a 66-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module rfpd_sqrt
    import rfpd_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [65:0] radicand,
    input  side_t       side_in,
    output logic [32:0] root,
    output side_t       side_out
);

    logic [34:0] rem_reg  [SQ_STEPS];
    logic [32:0] root_reg [SQ_STEPS];
    logic [65:0] x_reg    [SQ_STEPS];
    side_t       side_reg [SQ_STEPS];

    genvar i;
    generate
        for (i = 0; i < SQ_STEPS; i++)
        begin : g_step
            logic [34:0] rem_i;
            logic [32:0] root_i;
            logic [65:0] x_i;
            side_t       side_i;
            logic [36:0] cur;
            logic [36:0] trial;
            logic [36:0] diff;
            logic        ge;

            if (i == 0)
            begin : g_first
                assign rem_i  = '0;
                assign root_i = '0;
                assign x_i    = radicand;
                assign side_i = side_in;
            end
            else
            begin : g_next
                assign rem_i  = rem_reg[i-1];
                assign root_i = root_reg[i-1];
                assign x_i    = x_reg[i-1];
                assign side_i = side_reg[i-1];
            end

            // Bring down two radicand bits and try the next root bit.
            assign cur   = {rem_i, x_i[65:64]};
            assign trial = {2'b00, root_i, 2'b01};
            assign ge    = (cur >= trial);
            assign diff  = cur - trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= ge ? diff[34:0] : cur[34:0];
                    root_reg[i] <= {root_i[31:0], ge};
                    x_reg[i]    <= {x_i[63:0], 2'b00};
                    side_reg[i] <= side_i;
                end
            end
        end
    endgenerate

    assign root     = root_reg[SQ_STEPS-1];
    assign side_out = side_reg[SQ_STEPS-1];

endmodule

FILE: rtl/rfpd_dir.sv
// ----------------------------------------------------------------------------
// rfpd_dir: direction component scaled by force
// Pipelined divide of |d| by the length, sign restore, then force multiply.
// ----------------------------------------------------------------------------
module rfpd_dir
    import rfpd_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        a,
    input  logic               neg,
    input  logic [32:0]        len,
    input  logic signed [31:0] force_amount,
    output logic signed [33:0] f
);

    logic [47:0]          rem_reg  [DIR_QBITS];
    logic [32:0]          den_reg  [DIR_QBITS];
    logic [DIR_QBITS-1:0] q_reg    [DIR_QBITS];
    logic                 neg_reg  [DIR_QBITS];
    logic                 zero_reg [DIR_QBITS];

    logic signed [17:0] u_reg;
    logic signed [33:0] f_reg;
    logic [17:0]        mag;
    logic signed [49:0] prod;

    genvar i;
    generate
        for (i = 0; i < DIR_QBITS; i++)
        begin : g_step
            logic [47:0]          rem_i;
            logic [32:0]          den_i;
            logic [DIR_QBITS-1:0] q_i;
            logic                 neg_i;
            logic                 zero_i;
            logic [49:0]          sub;
            logic [49:0]          diff;
            logic                 ge;
            logic [DIR_QBITS-1:0] q_n;

            if (i == 0)
            begin : g_first
                assign rem_i  = {a, 16'b0};
                assign den_i  = len;
                assign q_i    = '0;
                assign neg_i  = neg;
                assign zero_i = (len == '0);
            end
            else
            begin : g_next
                assign rem_i  = rem_reg[i-1];
                assign den_i  = den_reg[i-1];
                assign q_i    = q_reg[i-1];
                assign neg_i  = neg_reg[i-1];
                assign zero_i = zero_reg[i-1];
            end

            // Restoring step for quotient bit DIR_QBITS-1-i.
            assign sub  = 50'(den_i) << (DIR_QBITS - 1 - i);
            assign ge   = ({2'b00, rem_i} >= sub);
            assign diff = {2'b00, rem_i} - sub;

            always_comb
            begin
                q_n = q_i;
                q_n[DIR_QBITS-1-i] = ge;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= ge ? diff[47:0] : rem_i;
                    den_reg[i]  <= den_i;
                    q_reg[i]    <= q_n;
                    neg_reg[i]  <= neg_i;
                    zero_reg[i] <= zero_i;
                end
            end
        end
    endgenerate

    // A zero length gives a zero direction.
    assign mag  = zero_reg[DIR_QBITS-1] ? '0 : {1'b0, q_reg[DIR_QBITS-1]};
    assign prod = u_reg * force_amount;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= neg_reg[DIR_QBITS-1] ? -$signed(mag) : $signed(mag);
            f_reg <= prod[49:FRAC_BITS];
        end
    end

    assign f = f_reg;

endmodule

FILE: rtl/rfpd_weight.sv
// ----------------------------------------------------------------------------
// rfpd_weight: smoothstep field weight
// Ramp (radius - length) / falloff clamped to [0, 1.0], then t*t*(3 - 2t).
// ----------------------------------------------------------------------------
module rfpd_weight
    import rfpd_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [32:0] len,
    input  logic [30:0] radius,
    input  logic [31:0] falloff,
    output logic [16:0] w
);

    logic [31:0] fo;
    logic        outside;
    logic [30:0] gap;

    logic [46:0] pre_rem_reg;
    logic [31:0] pre_den_reg;
    logic        pre_zero_reg;
    logic        pre_one_reg;

    logic [46:0]         rem_reg  [WT_QBITS];
    logic [31:0]         den_reg  [WT_QBITS];
    logic [WT_QBITS-1:0] q_reg    [WT_QBITS];
    logic                zero_reg [WT_QBITS];
    logic                one_reg  [WT_QBITS];

    logic [16:0] t;
    logic [33:0] t_sq;
    logic [16:0] t_reg;
    logic [16:0] t2_reg;
    logic [17:0] k;
    logic [34:0] w_prod;
    logic [16:0] w_reg;

    // Ramp setup: zero falloff acts as one lsb, far points get no weight.
    assign fo      = (falloff == '0) ? 32'd1 : falloff;
    assign outside = (len >= {2'b00, radius});
    assign gap     = radius - len[30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_rem_reg  <= {gap, 16'b0};
            pre_den_reg  <= fo;
            pre_zero_reg <= outside;
            pre_one_reg  <= ({1'b0, gap} >= fo);
        end
    end

    genvar i;
    generate
        for (i = 0; i < WT_QBITS; i++)
        begin : g_step
            logic [46:0]         rem_i;
            logic [31:0]         den_i;
            logic [WT_QBITS-1:0] q_i;
            logic                zero_i;
            logic                one_i;
            logic [47:0]         sub;
            logic [47:0]         diff;
            logic                ge;
            logic [WT_QBITS-1:0] q_n;

            if (i == 0)
            begin : g_first
                assign rem_i  = pre_rem_reg;
                assign den_i  = pre_den_reg;
                assign q_i    = '0;
                assign zero_i = pre_zero_reg;
                assign one_i  = pre_one_reg;
            end
            else
            begin : g_next
                assign rem_i  = rem_reg[i-1];
                assign den_i  = den_reg[i-1];
                assign q_i    = q_reg[i-1];
                assign zero_i = zero_reg[i-1];
                assign one_i  = one_reg[i-1];
            end

            // Restoring step for quotient bit WT_QBITS-1-i.
            assign sub  = 48'(den_i) << (WT_QBITS - 1 - i);
            assign ge   = ({1'b0, rem_i} >= sub);
            assign diff = {1'b0, rem_i} - sub;

            always_comb
            begin
                q_n = q_i;
                q_n[WT_QBITS-1-i] = ge;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= ge ? diff[46:0] : rem_i;
                    den_reg[i]  <= den_i;
                    q_reg[i]    <= q_n;
                    zero_reg[i] <= zero_i;
                    one_reg[i]  <= one_i;
                end
            end
        end
    endgenerate

    // Clamp the ramp and square it.
    always_comb
    begin
        if (zero_reg[WT_QBITS-1])
            t = '0;
        else if (one_reg[WT_QBITS-1])
            t = ONE;
        else
            t = {1'b0, q_reg[WT_QBITS-1]};
    end
    assign t_sq = t * t;

    // Smoothstep: t2 * (3.0 - 2.0 * t).
    assign k      = 18'(3 * ONE) - {t_reg, 1'b0};
    assign w_prod = t2_reg * k;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg  <= t;
            t2_reg <= t_sq[32:FRAC_BITS];
            w_reg  <= w_prod[32:FRAC_BITS];
        end
    end

    assign w = w_reg;

endmodule

FILE: rtl/radial_field_point_deformer.sv
// ----------------------------------------------------------------------------
// radial_field_point_deformer: pushes points along a radial smoothstep field
// An accepted point passes through 3 input stages, 33 square-root stages,
// 19 divide and weight stages and 2 output stages on the way to its result.
// Throughput is one point per cycle; a stalled output holds the whole pipeline.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module radial_field_point_deformer
    import rfpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    output logic        point_ready,
    input  point_t      point,
    output logic        moved_valid,
    input  logic        moved_ready,
    output moved_t      moved,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int LAT      = 3 + SQ_STEPS + DIR_QBITS + 2 + 2;
    localparam int P_DLY    = DIR_QBITS + 3;
    localparam int W_STAGE  = 3 + SQ_STEPS + DIR_QBITS + 2 - 1;

    logic signed [31:0] force_reg;
    logic [62:0]        radfall_reg;
    logic signed [31:0] centre_reg [3];
    logic signed [31:0] shift_reg  [3];

    logic [LAT-1:0] vld_reg;
    logic           adv;

    side_t       s0_reg;
    side_t       s1_reg;
    logic [63:0] sq_reg [3];
    side_t       s2_reg;
    logic [65:0] sum_reg;

    logic [32:0] len;
    side_t       sq_side;

    logic [2:0][31:0]   p_dly_reg [P_DLY];
    logic signed [33:0] f [3];
    logic [16:0]        w;
    logic signed [52:0] m_reg [3];
    moved_t             moved_reg;

    logic [2:0][31:0] p_in;

    // Configuration transactions are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_reg   <= '0;
            radfall_reg <= RADFALL_RESET;
            for (int j = 0; j < 3; j++)
            begin
                centre_reg[j] <= '0;
                shift_reg[j]  <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FORCE:    force_reg     <= cfg_data[31:0];
                CFG_RADFALL:  radfall_reg   <= cfg_data[62:0];
                CFG_CENTRE_X: centre_reg[0] <= cfg_data[31:0];
                CFG_CENTRE_Y: centre_reg[1] <= cfg_data[31:0];
                CFG_CENTRE_Z: centre_reg[2] <= cfg_data[31:0];
                CFG_SHIFT_X:  shift_reg[0]  <= cfg_data[31:0];
                CFG_SHIFT_Y:  shift_reg[1]  <= cfg_data[31:0];
                CFG_SHIFT_Z:  shift_reg[2]  <= cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    // The whole pipeline advances unless the result at its end is stalled.
    assign adv         = !vld_reg[LAT-1] || moved_ready;
    assign point_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], point_valid};
    end

    assign p_in[0] = point.point_x;
    assign p_in[1] = point.point_y;
    assign p_in[2] = point.point_z;

    // Offset from the centre, split into magnitude and sign.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                logic signed [32:0] d;
                logic signed [32:0] dm;
                d = $signed({p_in[j][31], p_in[j]}) -
                    $signed({centre_reg[j][31], centre_reg[j]});
                dm = d[32] ? -d : d;
                s0_reg.p[j]   <= p_in[j];
                s0_reg.a[j]   <= dm[31:0];
                s0_reg.neg[j] <= d[32];
            end
        end
    end

    // Squares, then their sum.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
                sq_reg[j] <= s0_reg.a[j] * s0_reg.a[j];
            s1_reg  <= s0_reg;
            sum_reg <= 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
            s2_reg  <= s1_reg;
        end
    end

    rfpd_sqrt u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (sum_reg),
        .side_in  (s2_reg),
        .root     (len),
        .side_out (sq_side)
    );

    genvar i;
    generate
        for (i = 0; i < 3; i++)
        begin : g_dir
            rfpd_dir u_dir (
                .clk          (clk),
                .en           (adv),
                .a            (sq_side.a[i]),
                .neg          (sq_side.neg[i]),
                .len          (len),
                .force_amount (force_reg),
                .f            (f[i])
            );
        end
    endgenerate

    rfpd_weight u_weight (
        .clk     (clk),
        .en      (adv),
        .len     (len),
        .radius  (radfall_reg[62:32]),
        .falloff (radfall_reg[31:0]),
        .w       (w)
    );

    // Point coordinates wait for the field terms.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_dly_reg[0] <= sq_side.p;
            for (int j = 1; j < P_DLY; j++)
                p_dly_reg[j] <= p_dly_reg[j-1];
        end
    end

    // Weighted push plus shift.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                logic signed [34:0] s;
                s = 35'(f[j]) + 35'(shift_reg[j]);
                m_reg[j] <= s * $signed({1'b0, w});
            end
        end
    end

    // Add to the point and saturate.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                logic signed [37:0] r;
                logic signed [31:0] c;
                r = $signed({{6{p_dly_reg[P_DLY-1][j][31]}}, p_dly_reg[P_DLY-1][j]}) +
                    $signed({m_reg[j][52], m_reg[j][52:FRAC_BITS]});
                if (r > 38'sd2147483647)
                    c = 32'sh7fffffff;
                else if (r < -38'sd2147483648)
                    c = 32'sh80000000;
                else
                    c = r[31:0];
                case (j)
                    0:       moved_reg.moved_x <= c;
                    1:       moved_reg.moved_y <= c;
                    default: moved_reg.moved_z <= c;
                endcase
            end
        end
    end

    assign moved_valid = vld_reg[LAT-1];
    assign moved       = moved_reg;

    // An accepted point enters the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready |=> vld_reg[0])
        else $error("accepted point did not enter the pipeline");

    // A stalled result freezes every stage.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        moved_valid && !moved_ready |=> $stable(vld_reg))
        else $error("pipeline moved during an output stall");

    // The field weight never exceeds one.
    a_weight: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[W_STAGE] |-> (w <= ONE))
        else $error("field weight above one");

endmodule

FILE: verif/rfpd_checker.sv
// ----------------------------------------------------------------------------
// rfpd_checker: prediction and comparison for the radial field point deformer
// Watches the configuration, point and result channels. It keeps its own copy
// of the registers and computes the deformed point of every accepted point.
// It then compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module rfpd_checker
    import rfpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    input  logic        point_ready,
    input  point_t      point,
    input  logic        moved_valid,
    input  logic        moved_ready,
    input  moved_t      moved,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int PRED_DEPTH = 128;

    // Shadow copy of the configuration registers.
    logic signed [31:0] force_amt;
    logic [62:0]        rad_fall;
    logic signed [31:0] centre [3];
    logic signed [31:0] shift [3];

    // Ring of predictions in acceptance order.
    moved_t predicted_mem [PRED_DEPTH];
    int     head_idx;
    int     tail_idx;

    // Floor square root of a sum of three squares (below 2^66).
    function automatic longint unsigned floor_sqrt(logic [67:0] n);
        logic [67:0] root;
        logic [67:0] cand;
        root = '0;
        for (int b = 33; b >= 0; b--)
        begin
            cand = root | (68'd1 << b);
            if (cand * cand <= n)
                root = cand;
        end
        return longint'(root);
    endfunction

    // Deformed point of one input point under the current registers.
    function automatic moved_t deform(point_t pt);
        longint             p [3];
        longint             d [3];
        longint unsigned    mag [3];
        logic [67:0]        sum;
        longint unsigned    len;
        longint unsigned    radius;
        longint unsigned    falloff;
        longint unsigned    q;
        longint             t;
        longint             t2;
        longint             w;
        longint             u;
        longint             f;
        longint             term;
        longint             r;
        logic signed [31:0] res [3];
        moved_t             out;
        p[0] = longint'(pt.point_x);
        p[1] = longint'(pt.point_y);
        p[2] = longint'(pt.point_z);
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = p[i] - longint'(centre[i]);
            mag[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
            sum = sum + 68'(mag[i]) * 68'(mag[i]);
        end
        len = floor_sqrt(sum);
        radius = longint'(rad_fall[62:32]);
        falloff = longint'(rad_fall[31:0]);
        if (falloff == 0)
            falloff = 1;
        // Smoothstep weight: zero at or beyond the radius.
        if (len >= radius)
            t = 0;
        else
        begin
            q = ((radius - len) << FRAC_BITS) / falloff;
            t = (q >= (64'd1 << FRAC_BITS)) ? (64'sd1 <<< FRAC_BITS) : longint'(q);
        end
        t2 = (t * t) >>> FRAC_BITS;
        w = (t2 * (3 * (64'sd1 <<< FRAC_BITS) - 2 * t)) >>> FRAC_BITS;
        for (int i = 0; i < 3; i++)
        begin
            // A point at the centre has no direction.
            u = 0;
            if (len != 0)
            begin
                u = longint'((mag[i] << FRAC_BITS) / len);
                if (d[i] < 0)
                    u = -u;
            end
            f = (u * longint'(force_amt)) >>> FRAC_BITS;
            term = ((f + longint'(shift[i])) * w) >>> FRAC_BITS;
            r = p[i] + term;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            res[i] = r[31:0];
        end
        out.moved_x = res[0];
        out.moved_y = res[1];
        out.moved_z = res[2];
        return out;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    assign pending = tail_idx - head_idx;

    initial
    begin
        fail_count = 0;
        head_idx = 0;
        tail_idx = 0;
    end

    // Track register writes, predict points and check results at each edge.
    always @(posedge clk or negedge rst_n)
    begin
        moved_t want;
        if (!rst_n)
        begin
            force_amt = '0;
            rad_fall = RADFALL_RESET;
            for (int i = 0; i < 3; i++)
            begin
                centre[i] = '0;
                shift[i] = '0;
            end
            head_idx = 0;
            tail_idx = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FORCE:    force_amt = cfg_data[31:0];
                    CFG_RADFALL:  rad_fall = cfg_data[62:0];
                    CFG_CENTRE_X: centre[0] = cfg_data[31:0];
                    CFG_CENTRE_Y: centre[1] = cfg_data[31:0];
                    CFG_CENTRE_Z: centre[2] = cfg_data[31:0];
                    CFG_SHIFT_X:  shift[0] = cfg_data[31:0];
                    CFG_SHIFT_Y:  shift[1] = cfg_data[31:0];
                    CFG_SHIFT_Z:  shift[2] = cfg_data[31:0];
                    default: ;
                endcase
            end
            if (point_valid && point_ready)
            begin
                if (tail_idx - head_idx >= PRED_DEPTH)
                begin
                    $error("too many point transactions waiting for results");
                    fail_count++;
                end
                else
                begin
                    predicted_mem[tail_idx % PRED_DEPTH] = deform(point);
                    tail_idx++;
                end
            end
            if (moved_valid && moved_ready)
            begin
                if (tail_idx == head_idx)
                begin
                    $error("result transaction with no point waiting");
                    fail_count++;
                end
                else
                begin
                    want = predicted_mem[head_idx % PRED_DEPTH];
                    head_idx++;
                    compare_field("moved_x", want.moved_x, moved.moved_x);
                    compare_field("moved_y", want.moved_y, moved.moved_y);
                    compare_field("moved_z", want.moved_z, moved.moved_z);
                end
            end
        end
    end

endmodule

FILE: verif/radial_field_point_deformer_test.sv
// ----------------------------------------------------------------------------
// radial_field_point_deformer_test: stimulus and verdict for the deformer
// Runs several register settings, extremes included, each with directed and
// random points under random idling on both sides. The checker predicts.
// ----------------------------------------------------------------------------
module radial_field_point_deformer_test;
    import rfpd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        point_valid;
    logic        point_ready;
    point_t      point;
    logic        moved_valid;
    logic        moved_ready;
    moved_t      moved;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending;
    bit          steady;

    localparam int DRAIN_CYCLES = 80;

    radial_field_point_deformer u_top (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready), .point(point),
        .moved_valid(moved_valid), .moved_ready(moved_ready), .moved(moved),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rfpd_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready), .point(point),
        .moved_valid(moved_valid), .moved_ready(moved_ready), .moved(moved),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side stalls at random except during a steady stretch.
    initial
    begin
        moved_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            moved_ready = steady || ($urandom_range(99) >= 10);
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One point transaction; valid stays high when no gap follows.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while (!steady && $urandom_range(99) < 10)
        begin
            point_valid = 1'b0;
            @(negedge clk);
        end
        point_valid = 1'b1;
        point.point_x = x;
        point.point_y = y;
        point.point_z = z;
        @(posedge clk);
        while (!point_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Called at a falling edge right after the last point transaction.
    task automatic wait_idle();
        point_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Coordinate near a centre, within about the given reach.
    function automatic logic [31:0] near(logic [31:0] c, longint unsigned reach);
        longint off;
        if (reach > 64'h7FFF_FFFF)
            reach = 64'h7FFF_FFFF;
        off = longint'($urandom_range(0, 32'(2 * reach))) - longint'(reach);
        return 32'(longint'($signed(c)) + off);
    endfunction

    logic [31:0] cen [3];
    logic [31:0] shf [3];
    logic [31:0] frc;
    logic [63:0] rf;

    task automatic load_setting(int ph);
        case (ph)
            1:
            begin
                // Strongest repel, widest radius, zero falloff, top bit set.
                frc = 32'h7FFF_FFFF;
                rf = {1'b1, 31'h7FFF_FFFF, 32'h0};
                cen = '{32'h0, 32'h0, 32'h0};
                shf = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            end
            2:
            begin
                // Strongest attract, falloff above radius, lowest shift.
                frc = 32'h8000_0000;
                rf = {32'h0003_0000, 32'h0008_0000};
                cen = '{$urandom, $urandom, $urandom};
                shf = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            end
            default:
            begin
                frc = $urandom;
                rf = {1'($urandom), 31'($urandom_range(0, 32'h0080_0000) << $urandom_range(0, 8)),
                      32'($urandom_range(0, 32'h0040_0000) << $urandom_range(0, 6))};
                cen = '{$urandom, $urandom, $urandom};
                for (int i = 0; i < 3; i++)
                    shf[i] = ($urandom_range(1)) ? $urandom : 32'($signed(20'($urandom)));
            end
        endcase
        write_reg(CFG_FORCE, {$urandom, frc});
        write_reg(CFG_RADFALL, rf);
        write_reg(CFG_CENTRE_X, {$urandom, cen[0]});
        write_reg(CFG_CENTRE_Y, {$urandom, cen[1]});
        write_reg(CFG_CENTRE_Z, {$urandom, cen[2]});
        write_reg(CFG_SHIFT_X, {$urandom, shf[0]});
        write_reg(CFG_SHIFT_Y, {$urandom, shf[1]});
        write_reg(CFG_SHIFT_Z, {$urandom, shf[2]});
    endtask

    // Main sequence: settings, directed points, random points, verdict.
    initial
    begin
        longint unsigned reach;
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        steady = 1'b0;
        cen = '{32'h0, 32'h0, 32'h0};
        shf = '{32'h0, 32'h0, 32'h0};
        frc = '0;
        rf = {1'b0, RADFALL_RESET};
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed points under the reset defaults.
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0000_4000, 32'h0, 32'h0);
        send_point(32'h0, 32'hFFFF_C000, 32'h0000_1000);
        send_point(32'h0000_8000, 32'h0, 32'h0);
        wait_idle();
        // A write to an unused index must change nothing.
        write_reg(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_point(32'h0000_2000, 32'h0000_2000, 32'h0);
        wait_idle();

        for (int ph = 1; ph <= 6; ph++)
        begin
            load_setting(ph);
            // Directed: centre itself, extremes and points near the radius.
            send_point(cen[0], cen[1], cen[2]);
            send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
            send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
            send_point(32'(cen[0] + rf[62:32]), cen[1], cen[2]);
            send_point(32'(cen[0] + rf[62:32] - 1), cen[1], cen[2]);
            send_point(cen[0], 32'(cen[1] - rf[62:32] + rf[31:0]), cen[2]);
            reach = longint'(rf[62:32]) + 16;
            for (int n = 0; n < 68; n++)
            begin
                steady = (n >= 30 && n < 50);
                if ($urandom_range(99) < 70)
                    send_point(near(cen[0], reach), near(cen[1], reach), near(cen[2], reach));
                else
                    send_point($urandom, $urandom, $urandom);
            end
            steady = 1'b0;
            wait_idle();
        end

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
